// ----- src/s2cw_pkg.sv -----
// Shared constants, widths and helper functions for the square-to-circle warp.
// No dependencies.
package s2cw_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CW_MIN           = 16;
  localparam int CW_MAX           = 32;

  localparam int PW  = 35;  // perimeter position
  localparam int RW  = 44;  // radius
  localparam int CXW = 34;  // cordic x/y, Q30
  localparam int ZAW = 34;  // cordic residual angle

  localparam logic signed [25:0]    FOUR_OVER_PI_Q24 = 26'sd21361415;
  localparam logic signed [CXW-1:0] CORDIC_GAIN_Q30  = CXW'(652032874);

  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_HOLE   = 1'b1;

  localparam logic [31:0] WEIGHT_RST = 32'd16777216;
  localparam logic [31:0] HOLE_RST   = 32'd6710886;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // keep low cw bits, sign-extend to 32
  function automatic logic signed [31:0] sext_cw(input logic [31:0] v, input int cw);
    logic [31:0] s;
    s = v << (32 - cw);
    return $signed(s) >>> (32 - cw);
  endfunction

  // saturate to the cw-bit signed range, result sign-extended to 32 bits
  function automatic logic [31:0] sat_cw(input logic signed [63:0] v, input int cw);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    hi = (64'sd1 <<< (cw - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    r  = (v > hi) ? hi : ((v < lo) ? lo : v);
    return r[31:0];
  endfunction

endpackage

// ----- src/s2cw_if.sv -----
// Handshake channels for points going in and results coming out.
// Depends on nothing.
interface s2cw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  logic [31:0] acc_z;
  modport source (output valid, in_x, in_y, in_z, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface s2cw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        origin_flag;
  modport source (output valid, out_x, out_y, out_z, origin_flag, input ready);
  modport sink   (input valid, out_x, out_y, out_z, origin_flag, output ready);
endinterface

// ----- src/square_to_circle_warp.sv -----
// Square-to-circle warp: one point per cycle, fully pipelined with a common stall.
// Pipeline: 5 front stages, 33 divider stages, CORDIC_STEPS + 2 CORDIC stages,
// 2 output multiply stages.
// Throughput one item per clock; the whole pipe holds when the output is stalled.
// Synchronous reset clears valid bits and sets weight = 1.0, hole_offset = 0.4.
// Uses s2cw_pkg, s2cw_if, s2cw_div, s2cw_cordic.
module square_to_circle_warp #(
  parameter int COORD_WIDTH  = s2cw_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = s2cw_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  s2cw_in_if.sink     points,
  s2cw_out_if.source  results
);

  localparam int CW = (COORD_WIDTH < s2cw_pkg::CW_MIN) ? s2cw_pkg::CW_MIN :
                      ((COORD_WIDTH > s2cw_pkg::CW_MAX) ? s2cw_pkg::CW_MAX : COORD_WIDTH);
  localparam int PW  = s2cw_pkg::PW;
  localparam int RW  = s2cw_pkg::RW;
  localparam int CXW = s2cw_pkg::CXW;
  localparam int SW  = 32 + 32 + 32 + RW + 1;

  logic [31:0] weight;
  logic [31:0] hole_offset;
  logic signed [31:0] w;
  logic signed [31:0] h;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight      <= s2cw_pkg::WEIGHT_RST;
      hole_offset <= s2cw_pkg::HOLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        s2cw_pkg::REG_WEIGHT: weight      <= cfg_data;
        s2cw_pkg::REG_HOLE:   hole_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w = s2cw_pkg::sext_cw(weight, CW);
  assign h = s2cw_pkg::sext_cw(hole_offset, CW);

  logic adv;
  logic v_out;
  assign adv          = !v_out || results.ready;
  assign points.ready = adv;

  // stage 1: input capture
  logic               v1;
  logic signed [31:0] x1, y1, z1, ax1, ay1, az1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= points.valid;
    if (adv) begin
      x1  <= s2cw_pkg::sext_cw(points.in_x, CW);
      y1  <= s2cw_pkg::sext_cw(points.in_y, CW);
      z1  <= s2cw_pkg::sext_cw(points.in_z, CW);
      ax1 <= s2cw_pkg::sext_cw(points.acc_x, CW);
      ay1 <= s2cw_pkg::sext_cw(points.acc_y, CW);
      az1 <= s2cw_pkg::sext_cw(points.acc_z, CW);
    end
  end

  // stage 2: shell, perimeter position, products with weight
  logic [31:0]        absx, absy, side_c;
  logic signed [35:0] sx, sy, sax, say, per_c;
  logic               v2, org2;
  logic [PW-1:0]      per2;
  logic [31:0]        side2;
  logic signed [63:0] wz2;
  logic signed [64:0] wside2;
  logic signed [31:0] ax2, ay2, az2;

  always_comb begin
    absx = x1[31] ? (~x1 + 32'd1) : x1;
    absy = y1[31] ? (~y1 + 32'd1) : y1;
    sx   = 36'(x1);
    sy   = 36'(y1);
    sax  = $signed({4'b0, absx});
    say  = $signed({4'b0, absy});
    if (absx >= absy) begin
      side_c = absx;
      per_c  = (!x1[31] && (x1 >= absy)) ? (sax + sy) : (5 * sax - sy);
    end else begin
      side_c = absy;
      per_c  = (!y1[31] && (y1 >= absx)) ? (3 * say - sx) : (7 * say + sx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      per2   <= per_c[PW-1:0];
      side2  <= side_c;
      org2   <= side_c == 32'd0;
      wz2    <= w * z1;
      wside2 <= w * $signed({1'b0, side_c});
      ax2    <= ax1;
      ay2    <= ay1;
      az2    <= az1;
    end
  end

  // stage 3: z result, scaled side
  logic               v3, org3;
  logic [PW-1:0]      per3;
  logic [31:0]        side3, zo3;
  logic signed [40:0] t3;
  logic signed [31:0] ax3, ay3;
  logic signed [63:0] zsum;
  assign zsum = 64'(az2) + 64'(wz2 >>> 24);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      per3  <= per2;
      side3 <= side2;
      org3  <= org2;
      zo3   <= s2cw_pkg::sat_cw(zsum, CW);
      t3    <= wside2[64:24];
      ax3   <= ax2;
      ay3   <= ay2;
    end
  end

  // stage 4: times 4/pi
  logic               v4, org4;
  logic [PW-1:0]      per4;
  logic [31:0]        side4, zo4;
  logic signed [66:0] rt4;
  logic signed [31:0] ax4, ay4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      per4  <= per3;
      side4 <= side3;
      org4  <= org3;
      zo4   <= zo3;
      rt4   <= t3 * s2cw_pkg::FOUR_OVER_PI_Q24;
      ax4   <= ax3;
      ay4   <= ay3;
    end
  end

  // stage 5: radius
  logic               v5, org5;
  logic [PW-1:0]      per5;
  logic [31:0]        side5, zo5;
  logic signed [RW-1:0] r5;
  logic signed [31:0] ax5, ay5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      per5  <= per4;
      side5 <= side4;
      org5  <= org4;
      zo5   <= zo4;
      r5    <= RW'(rt4 >>> 24) + RW'(h);
      ax5   <= ax4;
      ay5   <= ay4;
    end
  end

  // divider
  logic          vd;
  logic [31:0]   qd;
  logic [SW-1:0] sdd;
  s2cw_div #(.SIDE_W(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (v5),
    .perim     (per5),
    .side      (side5),
    .sd_in     ({ax5, ay5, zo5, r5, org5}),
    .valid_out (vd),
    .quo       (qd),
    .sd_out    (sdd)
  );

  // cordic; at the origin the ratio is forced to zero
  logic                  vc;
  logic signed [CXW-1:0] cosv, sinv;
  logic [SW-1:0]         sdc;
  s2cw_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(SW)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (vd),
    .ratio     (sdd[0] ? 32'd0 : qd),
    .sd_in     (sdd),
    .valid_out (vc),
    .cos_q30   (cosv),
    .sin_q30   (sinv),
    .sd_out    (sdc)
  );

  logic signed [31:0]   axc, ayc;
  logic [31:0]          zoc;
  logic signed [RW-1:0] rc;
  logic                 orgc;
  assign {axc, ayc, zoc, rc, orgc} = sdc;

  // multiply stage: radius split into high and low parts
  logic signed [RW-17:0]      rh;
  logic signed [16:0]         rl;
  assign rh = rc[RW-1:16];
  assign rl = $signed({1'b0, rc[15:0]});

  logic                         vm, orgm;
  logic signed [RW-16+CXW-1:0]  phx, phy;
  logic signed [17+CXW-1:0]     plx, ply;
  logic signed [31:0]           axm, aym;
  logic [31:0]                  zom;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= vc;
    if (adv) begin
      phx  <= rh * cosv;
      phy  <= rh * sinv;
      plx  <= rl * cosv;
      ply  <= rl * sinv;
      axm  <= axc;
      aym  <= ayc;
      zom  <= zoc;
      orgm <= orgc;
    end
  end

  // output stage
  logic signed [RW+CXW+1:0] prx, pry;
  logic signed [63:0]       sumx, sumy;
  assign prx  = ((RW+CXW+2)'(phx) <<< 16) + (RW+CXW+2)'(plx);
  assign pry  = ((RW+CXW+2)'(phy) <<< 16) + (RW+CXW+2)'(ply);
  assign sumx = 64'(prx >>> 30) + 64'(axm);
  assign sumy = 64'(pry >>> 30) + 64'(aym);

  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (adv) v_out <= vm;
    if (adv) begin
      results.out_x       <= s2cw_pkg::sat_cw(sumx, CW);
      results.out_y       <= s2cw_pkg::sat_cw(sumy, CW);
      results.out_z       <= zom;
      results.origin_flag <= orgm;
    end
  end

  assign results.valid = v_out;

endmodule

// ----- src/s2cw_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: q = perim*2^29 / side.
// Uses s2cw_pkg.
module s2cw_div #(
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      valid_in,
  input  logic [s2cw_pkg::PW-1:0]   perim,
  input  logic [31:0]               side,
  input  logic [SIDE_W-1:0]         sd_in,
  output logic                      valid_out,
  output logic [31:0]               quo,
  output logic [SIDE_W-1:0]         sd_out
);

  logic [31:0]       rem  [0:32];
  logic [31:0]       qv   [0:32];
  logic [31:0]       dsr  [0:32];
  logic [2:0]        plo  [0:32];
  logic [SIDE_W-1:0] sd   [0:32];
  logic              v    [0:32];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= valid_in;
    if (adv) begin
      rem[0] <= perim[s2cw_pkg::PW-1:3];
      qv[0]  <= '0;
      dsr[0] <= side;
      plo[0] <= perim[2:0];
      sd[0]  <= sd_in;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_step
    logic        nb;
    logic [32:0] trial;
    logic        ge;
    if (31 - j >= 29) begin : g_lo
      assign nb = plo[j][31-j-29];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign trial = {rem[j], nb};
    assign ge    = trial >= {1'b0, dsr[j]};

    always_ff @(posedge clk) begin
      if (rst) v[j+1] <= 1'b0;
      else if (adv) v[j+1] <= v[j];
      if (adv) begin
        rem[j+1] <= ge ? 32'(trial - {1'b0, dsr[j]}) : trial[31:0];
        qv[j+1]  <= {qv[j][30:0], ge};
        dsr[j+1] <= dsr[j];
        plo[j+1] <= plo[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign valid_out = v[32];
  assign quo       = qv[32];
  assign sd_out    = sd[32];

endmodule

// ----- src/s2cw_cordic.sv -----
// Pipelined rotation CORDIC, one step per stage, with half-turn folding.
// Uses s2cw_pkg.
module s2cw_cordic #(
  parameter int STEPS  = s2cw_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               valid_in,
  input  logic [31:0]                        ratio,
  input  logic [SIDE_W-1:0]                  sd_in,
  output logic                               valid_out,
  output logic signed [s2cw_pkg::CXW-1:0]    cos_q30,
  output logic signed [s2cw_pkg::CXW-1:0]    sin_q30,
  output logic [SIDE_W-1:0]                  sd_out
);

  localparam int CXW = s2cw_pkg::CXW;
  localparam int ZAW = s2cw_pkg::ZAW;

  logic signed [CXW-1:0] cx [0:STEPS];
  logic signed [CXW-1:0] cy [0:STEPS];
  logic signed [ZAW-1:0] za [0:STEPS];
  logic                  fl [0:STEPS];
  logic [SIDE_W-1:0]     sd [0:STEPS];
  logic                  v  [0:STEPS];

  logic [31:0] phase;
  logic        flip;
  logic [31:0] ph_f;

  assign phase = ratio - 32'h2000_0000;
  assign flip  = phase[31] ^ phase[30];
  assign ph_f  = flip ? {~phase[31], phase[30:0]} : phase;

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= valid_in;
    if (adv) begin
      cx[0] <= s2cw_pkg::CORDIC_GAIN_Q30;
      cy[0] <= '0;
      za[0] <= ZAW'($signed(ph_f));
      fl[0] <= flip;
      sd[0] <= sd_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ZAW-1:0] DA = ZAW'(s2cw_pkg::atan_turn(i));
    logic signed [CXW-1:0] dx;
    logic signed [CXW-1:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
      if (adv) begin
        if (!za[i][ZAW-1]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          za[i+1] <= za[i] - DA;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          za[i+1] <= za[i] + DA;
        end
        fl[i+1] <= fl[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  logic v_o;
  always_ff @(posedge clk) begin
    if (rst) v_o <= 1'b0;
    else if (adv) v_o <= v[STEPS];
    if (adv) begin
      cos_q30 <= fl[STEPS] ? -cx[STEPS] : cx[STEPS];
      sin_q30 <= fl[STEPS] ? -cy[STEPS] : cy[STEPS];
      sd_out  <= sd[STEPS];
    end
  end

  assign valid_out = v_o;

endmodule
